### hw/rtl/stkt_pkg.sv
// Constants, lookup tables and types for the serial-to-keystroke translator.
// Used by serial_to_keystroke_translator; depends on nothing else.

package stkt_pkg;

    // Escape-sequence buffer depth; a run of digits flushes one entry short of it
    localparam int SEQ_BUFFER_DEPTH = 8;
    localparam int BUF_AW           = $clog2(SEQ_BUFFER_DEPTH);
    localparam int NUM_SEQ          = 20;
    localparam int SEQ_IDX_W        = $clog2(NUM_SEQ);

    localparam logic [7:0] ESC_BYTE     = 8'h1b;
    localparam logic [7:0] CSI_BYTE     = 8'h5b;  // '['
    localparam logic [7:0] SEMI_BYTE    = 8'h3b;  // ';'
    localparam logic [7:0] DIGIT_LO     = 8'h30;  // '0'
    localparam logic [7:0] DIGIT_HI     = 8'h39;  // '9'
    localparam logic [7:0] RELEASE_MASK = 8'h80;

    // One known VT sequence: ESC '[' then up to three tail bytes
    typedef struct packed {
        logic [7:0] key;
        logic [2:0] len;
        logic [7:0] tail0;
        logic [7:0] tail1;
        logic [7:0] tail2;
    } vt_seq_t;

    localparam vt_seq_t VT_SEQS [NUM_SEQ] = '{
        '{8'h3b, 3'd3, 8'h44, 8'h00, 8'h00},  // ESC [ D
        '{8'h3c, 3'd3, 8'h41, 8'h00, 8'h00},  // ESC [ A
        '{8'h3d, 3'd3, 8'h43, 8'h00, 8'h00},  // ESC [ C
        '{8'h3e, 3'd3, 8'h42, 8'h00, 8'h00},  // ESC [ B
        '{8'h36, 3'd3, 8'h48, 8'h00, 8'h00},  // ESC [ H
        '{8'h37, 3'd4, 8'h33, 8'h7e, 8'h00},  // ESC [ 3 ~
        '{8'h38, 3'd4, 8'h36, 8'h7e, 8'h00},  // ESC [ 6 ~
        '{8'h39, 3'd4, 8'h35, 8'h7e, 8'h00},  // ESC [ 5 ~
        '{8'h3f, 3'd3, 8'h46, 8'h00, 8'h00},  // ESC [ F
        '{8'h63, 3'd5, 8'h31, 8'h31, 8'h7e},  // ESC [ 1 1 ~
        '{8'h64, 3'd5, 8'h31, 8'h32, 8'h7e},
        '{8'h65, 3'd5, 8'h31, 8'h33, 8'h7e},
        '{8'h66, 3'd5, 8'h31, 8'h34, 8'h7e},
        '{8'h67, 3'd5, 8'h31, 8'h35, 8'h7e},
        '{8'h68, 3'd5, 8'h31, 8'h37, 8'h7e},
        '{8'h69, 3'd5, 8'h31, 8'h38, 8'h7e},
        '{8'h6a, 3'd5, 8'h31, 8'h39, 8'h7e},
        '{8'h6b, 3'd5, 8'h32, 8'h30, 8'h7e},
        '{8'h6c, 3'd5, 8'h32, 8'h31, 8'h7e},
        '{8'h5e, 3'd4, 8'h32, 8'h7e, 8'h00}   // ESC [ 2 ~
    };

    // Plain character map: modifier in the upper byte, key in the lower byte
    localparam logic [15:0] PLAIN_MAP [128] = '{
        16'h0000, 16'h711e, 16'h712e, 16'h712c, 16'h7120, 16'h7113, 16'h7121, 16'h7122,
        16'h000f, 16'h0010, 16'h7124, 16'h7125, 16'h7126, 16'h001d, 16'h712f, 16'h7119,
        16'h711a, 16'h7111, 16'h7114, 16'h711f, 16'h7115, 16'h7117, 16'h712d, 16'h7112,
        16'h712b, 16'h7116, 16'h712a, 16'h0001, 16'h710e, 16'h7129, 16'h710d, 16'h7134,
        16'h0035, 16'h7002, 16'h7003, 16'h7004, 16'h7005, 16'h7006, 16'h7007, 16'h7008,
        16'h7009, 16'h700a, 16'h7028, 16'h7027, 16'h0031, 16'h000c, 16'h0032, 16'h0033,
        16'h000b, 16'h0002, 16'h0003, 16'h0004, 16'h0005, 16'h0006, 16'h0007, 16'h0008,
        16'h0009, 16'h000a, 16'h0028, 16'h0027, 16'h7031, 16'h700c, 16'h7032, 16'h7033,
        16'h001b, 16'h701e, 16'h702e, 16'h702c, 16'h7020, 16'h7013, 16'h7021, 16'h7022,
        16'h7023, 16'h7018, 16'h7024, 16'h7025, 16'h7026, 16'h7030, 16'h702f, 16'h7019,
        16'h701a, 16'h7011, 16'h7014, 16'h701f, 16'h7015, 16'h7017, 16'h702d, 16'h7012,
        16'h702b, 16'h7016, 16'h702a, 16'h001c, 16'h000e, 16'h0029, 16'h000d, 16'h7034,
        16'h701b, 16'h001e, 16'h002e, 16'h002c, 16'h0020, 16'h0013, 16'h0021, 16'h0022,
        16'h0023, 16'h0018, 16'h0024, 16'h0025, 16'h0026, 16'h0030, 16'h002f, 16'h0019,
        16'h001a, 16'h0011, 16'h0014, 16'h001f, 16'h0015, 16'h0017, 16'h002d, 16'h0012,
        16'h002b, 16'h0016, 16'h002a, 16'h701c, 16'h700e, 16'h7029, 16'h700d, 16'h0037
    };

endpackage

### hw/rtl/serial_to_keystroke_translator.sv
// Serial-to-keystroke translator: received bytes in, keyboard scancodes out.
// Depends on stkt_pkg for the character map, the VT sequence list and constants.
//
// Usage:
//   s_ channel takes one received byte per request (s_tdata). m_ channel gives
//   scancodes (m_tdata, bit 7 set = release); m_tlast marks the final scancode
//   caused by one input byte. A byte that causes no scancode gives no request.
//   The block takes one byte at a time: s_tready is high only while idle.
//   A plain byte steps through the press/release phases, then a drain of the
//   held code. A finished escape sequence first walks the 20-entry VT list through
//   one shared compare unit, one entry per cycle, then emits; a flush of the
//   buffer loads each buffered byte in turn and steps through its press/release
//   phases; the longest flush is of seven bytes, after a failed match.
//   Scancodes pass through a one-entry staging register and a registered output,
//   so the last flag is known before a scancode leaves. When m_tready is low the
//   emitter holds and resumes without loss.
//   Reset clears the escape buffer count, the sequencer and the output valid.

module serial_to_keystroke_translator (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] scan_code
    output logic       m_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_LOAD,
        ST_EMIT,
        ST_FINISH
    } state_t;

    localparam int AW = stkt_pkg::BUF_AW;
    localparam int SW = stkt_pkg::SEQ_IDX_W;
    localparam logic [AW-1:0] FLUSH_LEVEL = AW'(stkt_pkg::SEQ_BUFFER_DEPTH - 1);
    localparam logic [SW-1:0] SEQ_LAST    = SW'(stkt_pkg::NUM_SEQ - 1);

    state_t          state_reg, state_next;
    logic [AW-1:0]   cnt_reg, cnt_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [SW-1:0]   seq_reg, seq_next;
    logic [15:0]     kc_reg, kc_next;
    logic [1:0]      phase_reg, phase_next;
    logic            flushing_reg, flushing_next;
    logic            stage_valid_reg, stage_valid_next;
    logic [7:0]      stage_code_reg, stage_code_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      out_code_reg, out_code_next;
    logic            out_last_reg, out_last_next;

    logic [7:0]      buf_mem [stkt_pkg::SEQ_BUFFER_DEPTH];
    logic            buf_we;

    logic            out_free;
    logic            gen_ok;
    logic [7:0]      mod_code;
    logic [7:0]      key_code;
    logic [7:0]      phase_code;
    logic            phase_has;
    logic            is_digit;
    logic [AW-1:0]   cnt_inc;
    stkt_pkg::vt_seq_t cur_seq;
    logic            seq_hit;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_code_reg;
    assign m_tlast  = out_last_reg;

    assign out_free = !out_valid_reg || m_tready;
    assign gen_ok   = !stage_valid_reg || out_free;
    assign mod_code = kc_reg[15:8];
    assign key_code = kc_reg[7:0];
    assign is_digit = ((s_tdata >= stkt_pkg::DIGIT_LO) && (s_tdata <= stkt_pkg::DIGIT_HI))
                      || (s_tdata == stkt_pkg::SEMI_BYTE);
    assign cnt_inc  = cnt_reg + AW'(1);

    // Shared compare unit: one VT entry against the buffered tail per cycle
    assign cur_seq = stkt_pkg::VT_SEQS[seq_reg];
    assign seq_hit = (cur_seq.len == 3'(cnt_reg))
                     && (buf_mem[2] == cur_seq.tail0)
                     && ((cur_seq.len < 3'd4) || (buf_mem[3] == cur_seq.tail1))
                     && ((cur_seq.len < 3'd5) || (buf_mem[4] == cur_seq.tail2));

    // Select the code of the current press/release phase
    always_comb begin
        unique case (phase_reg)
            2'd0: begin
                phase_code = mod_code;
                phase_has  = (mod_code != 8'h00);
            end
            2'd1: begin
                phase_code = key_code;
                phase_has  = 1'b1;
            end
            2'd2: begin
                phase_code = key_code | stkt_pkg::RELEASE_MASK;
                phase_has  = 1'b1;
            end
            default: begin
                phase_code = mod_code | stkt_pkg::RELEASE_MASK;
                phase_has  = (mod_code != 8'h00);
            end
        endcase
    end

    // Sequencer next-state logic
    always_comb begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        idx_next         = idx_reg;
        seq_next         = seq_reg;
        kc_next          = kc_reg;
        phase_next       = phase_reg;
        flushing_next    = flushing_reg;
        stage_valid_next = stage_valid_reg;
        stage_code_next  = stage_code_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_code_next    = out_code_reg;
        out_last_next    = out_last_reg;
        buf_we           = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    phase_next    = 2'd0;
                    flushing_next = 1'b0;
                    idx_next      = '0;
                    seq_next      = '0;
                    if (cnt_reg == '0) begin
                        if (s_tdata == stkt_pkg::ESC_BYTE) begin
                            buf_we     = 1'b1;
                            cnt_next   = cnt_inc;
                            state_next = ST_FINISH;
                        end else begin
                            kc_next    = stkt_pkg::PLAIN_MAP[s_tdata[6:0]];
                            state_next = ST_EMIT;
                        end
                    end else if (cnt_reg == AW'(1)) begin
                        buf_we   = 1'b1;
                        cnt_next = cnt_inc;
                        if (s_tdata != stkt_pkg::CSI_BYTE) begin
                            flushing_next = 1'b1;
                            state_next    = ST_LOAD;
                        end else begin
                            state_next = ST_FINISH;
                        end
                    end else begin
                        buf_we   = 1'b1;
                        cnt_next = cnt_inc;
                        if (is_digit) begin
                            if (cnt_inc >= FLUSH_LEVEL) begin
                                flushing_next = 1'b1;
                                state_next    = ST_LOAD;
                            end else begin
                                state_next = ST_FINISH;
                            end
                        end else begin
                            state_next = ST_MATCH;
                        end
                    end
                end
            end

            ST_MATCH: begin
                if (seq_hit) begin
                    kc_next    = {8'h00, cur_seq.key};
                    phase_next = 2'd0;
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end else if (seq_reg == SEQ_LAST) begin
                    flushing_next = 1'b1;
                    idx_next      = '0;
                    state_next    = ST_LOAD;
                end else begin
                    seq_next = seq_reg + SW'(1);
                end
            end

            // Fetch the next buffered byte's key, or close the flush
            ST_LOAD: begin
                if (idx_reg == cnt_reg) begin
                    cnt_next   = '0;
                    state_next = ST_FINISH;
                end else begin
                    kc_next    = stkt_pkg::PLAIN_MAP[buf_mem[idx_reg][6:0]];
                    idx_next   = idx_reg + AW'(1);
                    phase_next = 2'd0;
                    state_next = ST_EMIT;
                end
            end

            // Step through press/release phases; push codes through the stage
            ST_EMIT: begin
                if (kc_reg == 16'h0000) begin
                    state_next = flushing_reg ? ST_LOAD : ST_FINISH;
                end else if (!phase_has || gen_ok) begin
                    if (phase_has) begin
                        if (stage_valid_reg) begin
                            out_valid_next = 1'b1;
                            out_code_next  = stage_code_reg;
                            out_last_next  = 1'b0;
                        end
                        stage_valid_next = 1'b1;
                        stage_code_next  = phase_code;
                    end
                    phase_next = phase_reg + 2'd1;
                    if (phase_reg == 2'd3) begin
                        state_next = flushing_reg ? ST_LOAD : ST_FINISH;
                    end
                end
            end

            // Drain the held code with the last flag
            ST_FINISH: begin
                if (!stage_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_valid_next   = 1'b1;
                    out_code_next    = stage_code_reg;
                    out_last_next    = 1'b1;
                    stage_valid_next = 1'b0;
                    state_next       = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold sequencer state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            flushing_reg    <= 1'b0;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            flushing_reg    <= flushing_next;
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
        idx_reg        <= idx_next;
        seq_reg        <= seq_next;
        kc_reg         <= kc_next;
        phase_reg      <= phase_next;
        stage_code_reg <= stage_code_next;
        out_code_reg   <= out_code_next;
        out_last_reg   <= out_last_next;
    end

    // Escape buffer: write the accepted byte at the fill position
    always_ff @(posedge aclk) begin
        if (buf_we) begin
            buf_mem[cnt_reg] <= s_tdata;
        end
    end

endmodule

### test/testbench.sv
// Self-checking testbench for serial_to_keystroke_translator: a scoreboard predicts
// the scancodes of every accepted byte and checks each scancode that leaves the block.
// Depends on stkt_pkg (rtl) for buffer depth and character constants.

module testbench;

    localparam int STREAM_ITEMS = 480;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 100;

    // Character map: modifier in the upper byte, key in the lower byte
    localparam logic [15:0] CHAR_KEYMAP [128] = '{
        16'h0000, 16'h711e, 16'h712e, 16'h712c, 16'h7120, 16'h7113, 16'h7121, 16'h7122,
        16'h000f, 16'h0010, 16'h7124, 16'h7125, 16'h7126, 16'h001d, 16'h712f, 16'h7119,
        16'h711a, 16'h7111, 16'h7114, 16'h711f, 16'h7115, 16'h7117, 16'h712d, 16'h7112,
        16'h712b, 16'h7116, 16'h712a, 16'h0001, 16'h710e, 16'h7129, 16'h710d, 16'h7134,
        16'h0035, 16'h7002, 16'h7003, 16'h7004, 16'h7005, 16'h7006, 16'h7007, 16'h7008,
        16'h7009, 16'h700a, 16'h7028, 16'h7027, 16'h0031, 16'h000c, 16'h0032, 16'h0033,
        16'h000b, 16'h0002, 16'h0003, 16'h0004, 16'h0005, 16'h0006, 16'h0007, 16'h0008,
        16'h0009, 16'h000a, 16'h0028, 16'h0027, 16'h7031, 16'h700c, 16'h7032, 16'h7033,
        16'h001b, 16'h701e, 16'h702e, 16'h702c, 16'h7020, 16'h7013, 16'h7021, 16'h7022,
        16'h7023, 16'h7018, 16'h7024, 16'h7025, 16'h7026, 16'h7030, 16'h702f, 16'h7019,
        16'h701a, 16'h7011, 16'h7014, 16'h701f, 16'h7015, 16'h7017, 16'h702d, 16'h7012,
        16'h702b, 16'h7016, 16'h702a, 16'h001c, 16'h000e, 16'h0029, 16'h000d, 16'h7034,
        16'h701b, 16'h001e, 16'h002e, 16'h002c, 16'h0020, 16'h0013, 16'h0021, 16'h0022,
        16'h0023, 16'h0018, 16'h0024, 16'h0025, 16'h0026, 16'h0030, 16'h002f, 16'h0019,
        16'h001a, 16'h0011, 16'h0014, 16'h001f, 16'h0015, 16'h0017, 16'h002d, 16'h0012,
        16'h002b, 16'h0016, 16'h002a, 16'h701c, 16'h700e, 16'h7029, 16'h700d, 16'h0037
    };

    // Tails of the known VT sequences, each following ESC '['
    localparam int NUM_VT = 20;
    string vt_tails [NUM_VT] = '{
        "D", "A", "C", "B", "H", "3~", "6~", "5~", "F", "11~",
        "12~", "13~", "14~", "15~", "17~", "18~", "19~", "20~", "21~", "2~"
    };

    // Opening bytes: table extremes, high-bit bytes, double ESC, good and bad sequences
    localparam int NUM_OPENING = 26;
    localparam logic [7:0] OPENING_BYTES [NUM_OPENING] = '{
        8'h00, 8'hff, 8'h7f, 8'h80, 8'h9b,
        stkt_pkg::ESC_BYTE, stkt_pkg::ESC_BYTE,
        stkt_pkg::ESC_BYTE, stkt_pkg::CSI_BYTE, 8'h44,
        stkt_pkg::ESC_BYTE, stkt_pkg::CSI_BYTE, 8'h31, 8'h31, 8'h7e,
        stkt_pkg::ESC_BYTE, stkt_pkg::CSI_BYTE, 8'h31, 8'h32, 8'h33,
        stkt_pkg::SEMI_BYTE, 8'h34,
        stkt_pkg::ESC_BYTE, stkt_pkg::CSI_BYTE, 8'h35, 8'h00
    };

    // Predicts scancodes per received byte and checks the block's output order
    class keystroke_scoreboard;
        logic [8:0] expected_scans [$];   // {last, scan_code}
        logic [8:0] step_scans [$];
        logic [7:0] held_bytes [stkt_pkg::SEQ_BUFFER_DEPTH];
        int         held_count;
        int         errors;

        function new();
            held_count = 0;
            errors     = 0;
        endfunction

        function int waiting();
            return expected_scans.size();
        endfunction

        // Queue modifier press, key press, key release, modifier release
        function void emit_key(logic [15:0] keycode);
            logic [7:0] modifier;
            logic [7:0] key;
            modifier = keycode[15:8];
            key      = keycode[7:0];
            if (keycode == 16'h0000) return;
            if (modifier != 8'h00) step_scans.push_back({1'b0, modifier});
            step_scans.push_back({1'b0, key});
            step_scans.push_back({1'b0, key | stkt_pkg::RELEASE_MASK});
            if (modifier != 8'h00)
                step_scans.push_back({1'b0, modifier | stkt_pkg::RELEASE_MASK});
        endfunction

        // Send every held byte as a plain key and empty the buffer
        function void flush_held();
            for (int i = 0; i < held_count && i < stkt_pkg::SEQ_BUFFER_DEPTH; i++)
                emit_key(CHAR_KEYMAP[held_bytes[i][6:0]]);
            held_count = 0;
        endfunction

        // Key of a finished sequence, zero when it is not one of the known ones
        function logic [7:0] sequence_key();
            logic [7:0] key;
            key = 8'h00;
            if (held_bytes[0] != stkt_pkg::ESC_BYTE || held_bytes[1] != stkt_pkg::CSI_BYTE)
                return key;
            if (held_count == 3) begin
                case (held_bytes[2])
                    "D": key = 8'h3b;
                    "A": key = 8'h3c;
                    "C": key = 8'h3d;
                    "B": key = 8'h3e;
                    "H": key = 8'h36;
                    "F": key = 8'h3f;
                    default: key = 8'h00;
                endcase
            end else if (held_count == 4 && held_bytes[3] == "~") begin
                case (held_bytes[2])
                    "3": key = 8'h37;
                    "6": key = 8'h38;
                    "5": key = 8'h39;
                    "2": key = 8'h5e;
                    default: key = 8'h00;
                endcase
            end else if (held_count == 5 && held_bytes[4] == "~") begin
                case ({held_bytes[2], held_bytes[3]})
                    "11": key = 8'h63;
                    "12": key = 8'h64;
                    "13": key = 8'h65;
                    "14": key = 8'h66;
                    "15": key = 8'h67;
                    "17": key = 8'h68;
                    "18": key = 8'h69;
                    "19": key = 8'h6a;
                    "20": key = 8'h6b;
                    "21": key = 8'h6c;
                    default: key = 8'h00;
                endcase
            end
            return key;
        endfunction

        // Advance the escape state by one accepted byte and queue its scancodes
        function void note_byte(logic [7:0] rx);
            logic [7:0] hit_key;
            step_scans.delete();
            if (held_count == 0) begin
                if (rx == stkt_pkg::ESC_BYTE) begin
                    held_bytes[0] = rx;
                    held_count    = 1;
                end else begin
                    emit_key(CHAR_KEYMAP[rx[6:0]]);
                end
            end else if (held_count == 1) begin
                held_bytes[1] = rx;
                held_count    = 2;
                if (rx != stkt_pkg::CSI_BYTE) flush_held();
            end else begin
                if (held_count < stkt_pkg::SEQ_BUFFER_DEPTH) begin
                    held_bytes[held_count] = rx;
                    held_count++;
                end
                if ((rx >= stkt_pkg::DIGIT_LO && rx <= stkt_pkg::DIGIT_HI)
                    || rx == stkt_pkg::SEMI_BYTE) begin
                    if (held_count >= stkt_pkg::SEQ_BUFFER_DEPTH - 1) flush_held();
                end else begin
                    hit_key = sequence_key();
                    if (hit_key != 8'h00) begin
                        emit_key({8'h00, hit_key});
                        held_count = 0;
                    end else begin
                        flush_held();
                    end
                end
            end
            if (step_scans.size() > 0) step_scans[$][8] = 1'b1;
            foreach (step_scans[i]) expected_scans.push_back(step_scans[i]);
        endfunction

        // Compare one delivered scancode with the oldest prediction
        function void check_scan(logic [7:0] scan, logic tail);
            logic [8:0] want;
            if (expected_scans.size() == 0) begin
                $error("scan_code: none expected, got %h (last %b)", scan, tail);
                errors++;
                return;
            end
            want = expected_scans.pop_front();
            if (want[7:0] !== scan) begin
                $error("scan_code: expected %h, got %h", want[7:0], scan);
                errors++;
            end
            if (want[8] !== tail) begin
                $error("last: expected %b, got %b", want[8], tail);
                errors++;
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    keystroke_scoreboard scans = new();
    int  bytes_sent  = 0;
    bit  send_burst  = 1'b0;

    serial_to_keystroke_translator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Free-running clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Offer one byte after a random gap and hold it until the block takes it
    task automatic send_byte(input logic [7:0] rx);
        int gap;
        if (bytes_sent % 32 == 0) send_burst = ($urandom_range(0, 3) == 0);
        gap = send_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        do @(posedge aclk); while (!s_tready);
        scans.note_byte(rx);
        bytes_sent++;
    endtask

    function automatic logic [7:0] random_param_byte();
        int pick;
        pick = $urandom_range(0, 10);
        return (pick == 10) ? stkt_pkg::SEMI_BYTE : stkt_pkg::DIGIT_LO + 8'(pick);
    endfunction

    // Send ESC '[' and one known tail
    task automatic send_vt_sequence(input int idx);
        send_byte(stkt_pkg::ESC_BYTE);
        send_byte(stkt_pkg::CSI_BYTE);
        for (int i = 0; i < vt_tails[idx].len(); i++) send_byte(vt_tails[idx][i]);
    endtask

    // Send a sequence that goes wrong: bad second byte, odd parameters or terminator
    task automatic send_broken_sequence();
        int kind;
        int params;
        logic [7:0] rx;
        kind = $urandom_range(0, 2);
        send_byte(stkt_pkg::ESC_BYTE);
        if (kind == 0) begin
            do rx = 8'($urandom_range(0, 255)); while (rx == stkt_pkg::CSI_BYTE);
            send_byte(rx);
        end else begin
            send_byte(stkt_pkg::CSI_BYTE);
            params = (kind == 1) ? $urandom_range(0, 3) : $urandom_range(4, 6);
            for (int i = 0; i < params; i++) send_byte(random_param_byte());
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Reset, opening bytes, then a random mix of keys and sequences
    initial begin
        int  mix;
        bit  drained_once;
        drained_once = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NUM_OPENING; i++) send_byte(OPENING_BYTES[i]);

        while (bytes_sent < NUM_OPENING + STREAM_ITEMS) begin
            // Pause once mid-run until every predicted scancode has arrived
            if (!drained_once && bytes_sent > NUM_OPENING + STREAM_ITEMS / 2) begin
                drained_once = 1'b1;
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (scans.waiting() != 0);
            end
            mix = $urandom_range(0, 99);
            if (mix < 35)
                send_byte(8'($urandom_range(0, 255)));
            else if (mix < 75)
                send_vt_sequence($urandom_range(0, NUM_VT - 1));
            else
                send_broken_sequence();
        end
        s_tvalid <= 1'b0;

        // Drain the remaining predictions, then watch for strays
        while (scans.waiting() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (scans.errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // Accept scancodes with random stalls, one long hold-off, and bursts without stalls
    initial begin
        int  stall;
        int  scans_seen;
        bit  take_burst;
        scans_seen = 0;
        take_burst = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (scans_seen % 40 == 0) take_burst = ($urandom_range(0, 3) == 0);
            if (scans_seen == 200)
                stall = LONG_HOLD;
            else
                stall = take_burst ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            scans.check_scan(m_tdata, m_tlast);
            scans_seen++;
        end
    end

    // Give up after a generous fixed time
    initial begin
        #(20 * 1000000);
        $display("testbench: FAIL");
        $finish;
    end

endmodule
